>>> design/besc_pkg.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types and character codes for the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package besc_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_C   = 8'h63;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_UPPER_X   = 8'h58;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	localparam logic [7:0] COLOR_RESET  = 8'd28;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = 1;

	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       last;
	} cmd_t;

endpackage

`default_nettype wire

>>> design/besc_if.sv
// ----------------------------------------------------------------------------
// Escape decoder channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface besc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface besc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface besc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/backslash_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder
// A result passes through the command queue and the output register before it
// is offered. One request per cycle while the queue has room; a request that
// yields two bytes gives two results, absorbed by the two-entry command queue.
// Reset: mode returns to plain text, queue and output empty, color byte 28.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	besc_in_if.sink   src,
	besc_cfg_if.sink  cfg,
	besc_out_if.source dst
);
	import besc_pkg::*;

	logic q_push;
	logic q_ready;
	cmd_t q_in;
	logic q_pop;
	logic q_valid;
	cmd_t q_out;

	besc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.src     (src),
		.cfg     (cfg),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_in)
	);

	besc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_in),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (q_out)
	);

	besc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_out),
		.q_pop   (q_pop),
		.dst     (dst)
	);

endmodule

`default_nettype wire

>>> design/besc_front.sv
// ----------------------------------------------------------------------------
// Escape decoder front end
// Accepts requests, tracks the escape mode and issues up to two bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module besc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	besc_in_if.sink           src,
	besc_cfg_if.sink          cfg,
	input  wire logic         q_ready,
	output logic              q_push,
	output besc_pkg::cmd_t    q_cmd
);
	import besc_pkg::*;

	typedef enum logic [1:0] {
		M_PLAIN = 2'd0,
		M_ESC   = 2'd1,
		M_HEX   = 2'd2,
		M_OCT   = 2'd3
	} mode_t;

	mode_t      mode_q;
	logic [7:0] val_q;
	logic [1:0] cnt_q;
	logic [7:0] color_q;

	mode_t      nmode;
	logic [7:0] nval;
	logic [1:0] ncnt;
	logic       pre_emit;
	logic [7:0] pre_byte;
	logic       run_plain;
	logic       plain_emit;
	logic       hex_ok;
	logic [3:0] hex_d;
	logic       oct_ok;
	logic       take;
	logic [7:0] b;
	logic       last;

	assign b      = src.in_byte;
	assign last   = src.in_last;
	assign oct_ok = (b[7:3] == 5'b00110);

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = b[3:0];
		priority if (b >= 8'h30 && b <= 8'h39) begin
			hex_d = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			hex_d = b[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		nmode      = mode_q;
		nval       = val_q;
		ncnt       = cnt_q;
		pre_emit   = 1'b0;
		pre_byte   = CH_BACKSLASH;
		run_plain  = 1'b0;
		plain_emit = 1'b0;
		unique case (mode_q)
			M_PLAIN: begin
				run_plain = 1'b1;
			end
			M_ESC: begin
				nmode = M_PLAIN;
				priority if (b == CH_LOWER_C) begin
					pre_emit = 1'b1;
					pre_byte = color_q;
				end else if (b == CH_LOWER_N) begin
					pre_emit = 1'b1;
					pre_byte = CH_NEWLINE;
				end else if (b == CH_LOWER_T) begin
					pre_emit = 1'b1;
					pre_byte = CH_TAB;
				end else if (b == CH_LOWER_R) begin
					pre_emit = 1'b1;
					pre_byte = CH_CR;
				end else if (b == CH_LOWER_X || b == CH_UPPER_X) begin
					nmode    = M_HEX;
					nval     = 8'd0;
					ncnt     = 2'd0;
					pre_emit = last;
					pre_byte = 8'd0;
				end else if (oct_ok) begin
					nmode    = M_OCT;
					nval     = {5'd0, b[2:0]};
					ncnt     = 2'd1;
					pre_emit = last;
					pre_byte = {5'd0, b[2:0]};
				end else begin
					pre_emit  = 1'b1;
					pre_byte  = CH_BACKSLASH;
					run_plain = 1'b1;
				end
			end
			M_HEX: begin
				if (hex_ok) begin
					nval = {val_q[3:0], hex_d};
					ncnt = cnt_q + 2'd1;
					if (ncnt >= 2'd2 || last) begin
						pre_emit = 1'b1;
						pre_byte = nval;
						nmode    = M_PLAIN;
					end
				end else begin
					pre_emit  = 1'b1;
					pre_byte  = val_q;
					run_plain = 1'b1;
				end
			end
			M_OCT: begin
				if (oct_ok) begin
					nval = {val_q[4:0], b[2:0]};
					ncnt = cnt_q + 2'd1;
					if (ncnt == 2'd3 || last) begin
						pre_emit = 1'b1;
						pre_byte = nval;
						nmode    = M_PLAIN;
					end
				end else begin
					pre_emit  = 1'b1;
					pre_byte  = val_q;
					run_plain = 1'b1;
				end
			end
			default: begin
				nmode = M_PLAIN;
			end
		endcase
		if (run_plain) begin
			if (b == CH_BACKSLASH && !last) begin
				nmode = M_ESC;
			end else begin
				nmode      = M_PLAIN;
				plain_emit = 1'b1;
			end
		end
		if (nmode == M_PLAIN || last) begin
			nmode = (last) ? M_PLAIN : nmode;
			nval  = 8'd0;
			ncnt  = 2'd0;
		end
	end

	assign take       = src.valid && src.ready;
	assign src.ready  = q_ready;
	assign cfg.ready  = 1'b1;
	assign q_push     = take && (pre_emit || plain_emit);
	assign q_cmd.two  = pre_emit && plain_emit;
	assign q_cmd.b0   = pre_emit ? pre_byte : b;
	assign q_cmd.b1   = b;
	assign q_cmd.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_PLAIN;
			val_q   <= 8'd0;
			cnt_q   <= 2'd0;
			color_q <= COLOR_RESET;
		end else begin
			if (take) begin
				mode_q <= nmode;
				val_q  <= nval;
				cnt_q  <= ncnt;
			end
			if (cfg.valid) begin
				color_q <= cfg.data;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/besc_queue.sv
// ----------------------------------------------------------------------------
// Escape decoder command queue
// Two-entry queue that decouples the front end from the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module besc_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  besc_pkg::cmd_t    push_cmd,
	output logic              push_ready,
	input  wire logic         pop,
	output logic              pop_valid,
	output besc_pkg::cmd_t    pop_cmd
);
	import besc_pkg::*;

	cmd_t           ent_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = ent_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/besc_back.sv
// ----------------------------------------------------------------------------
// Escape decoder back end
// Drains queued commands and presents one decoded byte per result.
// ----------------------------------------------------------------------------
`default_nettype none

module besc_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  besc_pkg::cmd_t    q_cmd,
	output logic              q_pop,
	besc_out_if.source        dst
);
	import besc_pkg::*;

	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       pend_q;
	logic [7:0] pbyte_q;
	logic       plast_q;
	logic       load_ok;

	assign load_ok      = !ovalid_q || dst.ready;
	assign q_pop        = load_ok && !pend_q && q_valid;
	assign dst.valid    = ovalid_q;
	assign dst.out_byte = obyte_q;
	assign dst.out_last = olast_q;

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_q) begin
				obyte_q <= pbyte_q;
				olast_q <= plast_q;
			end else if (q_valid) begin
				obyte_q <= q_cmd.b0;
				olast_q <= q_cmd.last && !q_cmd.two;
				pbyte_q <= q_cmd.b1;
				plast_q <= q_cmd.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (load_ok) begin
			if (pend_q) begin
				ovalid_q <= 1'b1;
				pend_q   <= 1'b0;
			end else if (q_valid) begin
				ovalid_q <= 1'b1;
				pend_q   <= q_cmd.two;
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
